FILE: hdl/ntt_pkg.sv
// Shared types and constants for the 256-point NTT engine over Z_3329.
// Holds action codes, butterfly modes, arithmetic constants and the zeta table.
// No dependencies.
`default_nettype none
package ntt_pkg;

  localparam int POLY_LEN = 256;
  localparam int IDX_W    = $clog2(POLY_LEN);
  localparam int COEF_W   = 16;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_FWD   = 2'd1;
  localparam logic [1:0] ACT_INV   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic signed [15:0] MODQ      = 16'sd3329;
  localparam logic [15:0]        QINV      = 16'd62209;
  localparam logic signed [15:0] BARRETT_V = 16'sd20159;
  localparam logic signed [15:0] INV_SCALE = 16'sd1441;

  typedef enum logic [1:0] {
    MODE_FWD,
    MODE_INV,
    MODE_SCALE
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] zeta;
  } bfly_ctl_t;

  // Kyber zetas, Montgomery form, bit-reversed order
  localparam logic signed [15:0] ZETA [128] = '{
    -16'sd1044, -16'sd758, -16'sd359, -16'sd1517, 16'sd1493, 16'sd1422, 16'sd287, 16'sd202,
    -16'sd171, 16'sd622, 16'sd1577, 16'sd182, 16'sd962, -16'sd1202, -16'sd1474, 16'sd1468,
    16'sd573, -16'sd1325, 16'sd264, 16'sd383, -16'sd829, 16'sd1458, -16'sd1602, -16'sd130,
    -16'sd681, 16'sd1017, 16'sd732, 16'sd608, -16'sd1542, 16'sd411, -16'sd205, -16'sd1571,
    16'sd1223, 16'sd652, -16'sd552, 16'sd1015, -16'sd1293, 16'sd1491, -16'sd282, -16'sd1544,
    16'sd516, -16'sd8, -16'sd320, -16'sd666, -16'sd1618, -16'sd1162, 16'sd126, 16'sd1469,
    -16'sd853, -16'sd90, -16'sd271, 16'sd830, 16'sd107, -16'sd1421, -16'sd247, -16'sd951,
    -16'sd398, 16'sd961, -16'sd1508, -16'sd725, 16'sd448, -16'sd1065, 16'sd677, -16'sd1275,
    -16'sd1103, 16'sd430, 16'sd555, 16'sd843, -16'sd1251, 16'sd871, 16'sd1550, 16'sd105,
    16'sd422, 16'sd587, 16'sd177, -16'sd235, -16'sd291, -16'sd460, 16'sd1574, 16'sd1653,
    -16'sd246, 16'sd778, 16'sd1159, -16'sd147, -16'sd777, 16'sd1483, -16'sd602, 16'sd1119,
    -16'sd1590, 16'sd644, -16'sd872, 16'sd349, 16'sd418, 16'sd329, -16'sd156, -16'sd75,
    16'sd817, 16'sd1097, 16'sd603, 16'sd610, 16'sd1322, -16'sd1285, -16'sd1465, 16'sd384,
    -16'sd1215, -16'sd136, 16'sd1218, -16'sd1335, -16'sd874, 16'sd220, -16'sd1187, -16'sd1659,
    -16'sd1185, -16'sd1530, -16'sd1278, 16'sd794, -16'sd1510, -16'sd854, -16'sd870, 16'sd478,
    -16'sd108, -16'sd308, 16'sd996, 16'sd991, 16'sd958, -16'sd1460, 16'sd1522, 16'sd1628
  };

endpackage
`default_nettype wire

FILE: hdl/ntt_ram.sv
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none
module ntt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr_i,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr_i,
  output logic      [WIDTH-1:0]         ra_data_o,
  output logic      [WIDTH-1:0]         rb_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    ra_data_o <= mem_q[ra_addr_i];
    rb_data_o <= mem_q[rb_addr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/ntt_bfly.sv
// Shared butterfly unit: three register stages of products and Montgomery /
// Barrett reduction. Depends on ntt_pkg.
`default_nettype none
module ntt_bfly
  import ntt_pkg::*;
(
  input  wire logic               clk_i,
  input  wire bfly_ctl_t          ctl_i,
  input  wire logic signed [15:0] a_i,
  input  wire logic signed [15:0] b_i,
  output logic signed [15:0]      new_a_o,
  output logic signed [15:0]      new_b_o
);

  logic signed [15:0] opnd, zmul, sum;
  logic signed [31:0] prod_d;
  logic [31:0]        qinv_prod;
  logic signed [31:0] bar_prod;
  logic signed [31:0] red_d;
  logic signed [31:0] bar_d;

  logic signed [15:0] a_q, sum_q, t_q, r_q, bar_q;
  logic signed [31:0] prod_q, prod2_q;
  logic signed [5:0]  bt_q;
  logic signed [15:0] sum2_q, a2_q, a3_q;

  always_comb begin
    sum  = a_i + b_i;
    opnd = (ctl_i.mode == MODE_INV) ? 16'(b_i - a_i) : b_i;
    zmul = (ctl_i.mode == MODE_SCALE) ? INV_SCALE : ctl_i.zeta;
    prod_d = 32'(zmul) * 32'(opnd);
  end

  // stage 2: Montgomery quotient and Barrett quotient in parallel
  assign qinv_prod = 32'(prod_q[15:0]) * 32'(QINV);
  assign bar_prod  = 32'(sum_q) * 32'(BARRETT_V) + 32'sh0200_0000;

  // stage 3: final corrections
  assign red_d = prod2_q - 32'(t_q) * 32'(MODQ);
  assign bar_d = 32'(sum2_q) - 32'(bt_q) * 32'(MODQ);

  always_ff @(posedge clk_i) begin
    a_q     <= a_i;
    sum_q   <= sum;
    prod_q  <= prod_d;
    t_q     <= qinv_prod[15:0];
    bt_q    <= bar_prod[31:26];
    prod2_q <= prod_q;
    sum2_q  <= sum_q;
    a2_q    <= a_q;
    r_q     <= red_d[31:16];
    bar_q   <= bar_d[15:0];
    a3_q    <= a2_q;
  end

  always_comb begin
    if (ctl_i.mode == MODE_FWD) begin
      new_a_o = a3_q + r_q;
      new_b_o = a3_q - r_q;
    end else begin
      new_a_o = bar_q;
      new_b_o = r_q;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/polynomial_ntt_engine_top.sv
// Top level of the NTT engine: handshake, sequencer and coefficient store.
// Depends on ntt_pkg, ntt_ram, ntt_bfly.
`default_nettype none
// Holds one 256-coefficient polynomial mod 3329. A write item's result is
// registered directly; a read item passes through ST_RDW first. A forward
// transform runs 7 layers of 128 butterflies through one shared butterfly
// unit, each as read, three arithmetic stages and two write-backs through
// the single RAM write port. An inverse transform adds a 256-coefficient
// scaling pass of read, scale, write-back. No new item is taken meanwhile.
module polynomial_ntt_engine_top
  import ntt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           action_i,
  input  wire logic [7:0]           coef_index_i,
  input  wire logic signed [15:0]   coef_value_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic signed [15:0]        read_value_o,
  output logic [1:0]                action_done_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_RDW, ST_RD, ST_S1, ST_S2, ST_S3, ST_WA, ST_WB
  } state_e;
  localparam state_e ST_DONE_UNUSED = ST_IDLE;

  state_e         state_q;
  logic           done_q;
  logic [1:0]     act_q;
  mode_e          mode_q;
  logic [2:0]     sh_q;
  logic [IDX_W-1:0] idx_q;

  logic           accept, slot_free;
  logic [7:0]     c8, mask8, addr_a, addr_b, g8;
  logic [6:0]     k;
  bfly_ctl_t      ctl;
  logic           we;
  logic [IDX_W-1:0] waddr, ra_addr, rb_addr;
  logic [15:0]    wdata, ra_data, rb_data;
  logic signed [15:0] new_a, new_b;

  assign slot_free  = !out_valid_o || !out_stall_i;
  assign in_stall_o = !(state_q == ST_IDLE && !done_q && slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  // butterfly addresses: insert a zero at bit sh of the counter
  always_comb begin
    c8     = {1'b0, idx_q[6:0]};
    mask8  = 8'((9'd1 << sh_q) - 9'd1);
    addr_a = ((c8 & ~mask8) << 1) | (c8 & mask8);
    addr_b = addr_a | (8'd1 << sh_q);
    g8     = c8 >> sh_q;
    if (mode_q == MODE_FWD) begin
      k = 7'((8'd128 >> sh_q) + g8);
    end else begin
      // inverse walks the table downward from entry 127
      k = 7'((9'd256 >> sh_q) - 9'd1 - {1'b0, g8});
    end
    ctl.mode = mode_q;
    ctl.zeta = ZETA[k];
  end

  always_comb begin
    ra_addr = addr_a;
    rb_addr = (mode_q == MODE_SCALE || state_q == ST_RDW || state_q == ST_IDLE)
              ? idx_q : addr_b;
    we      = 1'b0;
    waddr   = coef_index_i;
    wdata   = coef_value_i;
    unique case (state_q)
      ST_IDLE: we = accept && (action_i == ACT_WRITE);
      ST_WA: begin
        we    = 1'b1;
        waddr = (mode_q == MODE_SCALE) ? idx_q : addr_a;
        wdata = (mode_q == MODE_SCALE) ? new_b : new_a;
      end
      ST_WB: begin
        we    = 1'b1;
        waddr = addr_b;
        wdata = new_b;
      end
      default: we = 1'b0;
    endcase
  end

  ntt_ram #(.WIDTH(COEF_W), .DEPTH(POLY_LEN)) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data)
  );

  ntt_bfly u_bfly (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .a_i     (ra_data),
    .b_i     (rb_data),
    .new_a_o (new_a),
    .new_b_o (new_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_DONE_UNUSED;
      done_q        <= 1'b0;
      act_q         <= ACT_WRITE;
      mode_q        <= MODE_FWD;
      sh_q          <= 3'd7;
      idx_q         <= '0;
      out_valid_o   <= 1'b0;
      read_value_o  <= '0;
      action_done_o <= ACT_WRITE;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      // finished item waits here for the output register
      if (done_q && slot_free) begin
        done_q        <= 1'b0;
        out_valid_o   <= 1'b1;
        action_done_o <= act_q;
        read_value_o  <= (act_q == ACT_READ) ? rb_data : 16'sd0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            act_q <= action_i;
            idx_q <= '0;
            unique case (action_i)
              ACT_WRITE: begin
                out_valid_o   <= 1'b1;
                action_done_o <= ACT_WRITE;
                read_value_o  <= 16'sd0;
              end
              ACT_FWD: begin
                mode_q  <= MODE_FWD;
                sh_q    <= 3'd7;
                state_q <= ST_RD;
              end
              ACT_INV: begin
                mode_q  <= MODE_INV;
                sh_q    <= 3'd1;
                state_q <= ST_RD;
              end
              ACT_READ: begin
                idx_q   <= coef_index_i;
                state_q <= ST_RDW;
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_RDW: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_RD: state_q <= ST_S1;
        ST_S1: state_q <= ST_S2;
        ST_S2: state_q <= ST_S3;
        ST_S3: state_q <= ST_WA;
        ST_WA: begin
          if (mode_q == MODE_SCALE) begin
            idx_q <= idx_q + 1'b1;
            if (idx_q == IDX_W'(POLY_LEN - 1)) begin
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              state_q <= ST_RD;
            end
          end else begin
            state_q <= ST_WB;
          end
        end
        ST_WB: begin
          idx_q   <= {1'b0, 7'(idx_q[6:0] + 7'd1)};
          state_q <= ST_RD;
          if (idx_q[6:0] == 7'd127) begin
            if (mode_q == MODE_FWD) begin
              if (sh_q == 3'd1) begin
                done_q  <= 1'b1;
                state_q <= ST_IDLE;
              end else begin
                sh_q <= sh_q - 3'd1;
              end
            end else if (sh_q == 3'd7) begin
              mode_q <= MODE_SCALE;
              idx_q  <= '0;
            end else begin
              sh_q <= sh_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: hdl/ntt_checker.sv
// Port-level checker for the NTT engine, bound to the top level.
// Depends on ntt_pkg and polynomial_ntt_engine_top.
`default_nettype none
module ntt_checker
  import ntt_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [1:0]         action_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic signed [15:0] read_value_o,
  input wire logic [1:0]         action_done_o
);

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_value_o)
      && $stable(action_done_o))
    else $error("result changed while stalled");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ACT_WRITE |=>
      out_valid_o && action_done_o == ACT_WRITE && read_value_o == 16'sd0)
    else $error("write item gave no immediate result");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_FWD || action_i == ACT_INV)
      |=> in_stall_o ##1 in_stall_o)
    else $error("new item taken during a transform");

  a_zero_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_done_o != ACT_READ |-> read_value_o == 16'sd0)
    else $error("nonzero value on a non-read result");

endmodule

bind polynomial_ntt_engine_top ntt_checker u_ntt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .action_i      (action_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .read_value_o  (read_value_o),
  .action_done_o (action_done_o)
);
`default_nettype wire

FILE: verif/ntt_checker.sv
// Scoreboard for the NTT engine: predicts each result from the accepted items
// and compares it with what the block returns. Depends on ntt_pkg.
module ntt_scoreboard
  import ntt_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         action_i,
  input  logic [7:0]         coef_index_i,
  input  logic signed [15:0] coef_value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] read_value_i,
  input  logic [1:0]         action_done_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] value;
    logic [1:0]         act;
  } result_t;

  logic signed [15:0] poly [POLY_LEN];
  result_t            results_q [$];

  function automatic logic signed [15:0] mont_red(input int a);
    logic [15:0] m;
    int          d;
    m = 16'(a[15:0] * QINV);
    d = a - int'($signed(m)) * int'(MODQ);
    return d[31:16];
  endfunction

  function automatic logic signed [15:0] barrett_red(input logic signed [15:0] a);
    int q;
    int r;
    q = (int'(BARRETT_V) * int'(a) + (1 << 25)) >>> 26;
    r = int'(a) - q * int'(MODQ);
    return r[15:0];
  endfunction

  task automatic ntt_forward();
    int                 k;
    logic signed [15:0] t;
    k = 1;
    for (int len = 128; len >= 2; len = len / 2) begin
      for (int s = 0; s < POLY_LEN; s += 2 * len) begin
        for (int j = s; j < s + len; j++) begin
          t = mont_red(int'(ZETA[k]) * int'(poly[j + len]));
          poly[j + len] = poly[j] - t;
          poly[j] = poly[j] + t;
        end
        k++;
      end
    end
  endtask

  task automatic ntt_inverse();
    int                 k;
    logic signed [15:0] t;
    logic signed [15:0] d;
    k = 127;
    for (int len = 2; len <= 128; len = len * 2) begin
      for (int s = 0; s < POLY_LEN; s += 2 * len) begin
        for (int j = s; j < s + len; j++) begin
          t = poly[j];
          poly[j] = barrett_red(t + poly[j + len]);
          d = poly[j + len] - t;
          poly[j + len] = mont_red(int'(ZETA[k]) * int'(d));
        end
        k--;
      end
    end
    for (int j = 0; j < POLY_LEN; j++)
      poly[j] = mont_red(int'(poly[j]) * int'(INV_SCALE));
  endtask

  initial begin
    errors_o  = 0;
    pending_o = 0;
    foreach (poly[i]) poly[i] = '0;
  end

  always @(posedge clk_i) begin
    result_t r;
    result_t got;
    if (rst_ni && in_valid_i && !in_stall_i) begin
      r.value = '0;
      r.act   = action_i;
      case (action_i)
        ACT_WRITE: poly[coef_index_i] = coef_value_i;
        ACT_FWD:   ntt_forward();
        ACT_INV:   ntt_inverse();
        ACT_READ:  r.value = poly[coef_index_i];
        default:   r.value = '0;
      endcase
      results_q.push_back(r);
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      if (results_q.size() == 0) begin
        $error("result item with nothing expected");
        errors_o++;
      end else begin
        got = results_q.pop_front();
        if (read_value_i !== got.value) begin
          $error("read_value: expected %0d, got %0d", got.value, read_value_i);
          errors_o++;
        end
        if (action_done_i !== got.act) begin
          $error("action_done: expected %0d, got %0d", got.act, action_done_i);
          errors_o++;
        end
      end
    end
    pending_o = results_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the NTT engine: clock, reset, item stimulus, output stall
// and verdict. Depends on ntt_pkg, polynomial_ntt_engine_top, ntt_scoreboard.
module tb_top;
  import ntt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_WRITE;
  logic [7:0]         coef_index = '0;
  logic signed [15:0] coef_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] read_value;
  logic [1:0]         action_done;
  logic               in_stall_s = 1'b1;
  logic               quiet = 1'b0;
  int                 errors;
  int                 pending;

  always #5 clk = ~clk;

  // stall only moves at rising edges, so the negedge copy is stable for the next edge
  always @(negedge clk) in_stall_s <= in_stall;

  polynomial_ntt_engine_top dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .coef_index_i(coef_index), .coef_value_i(coef_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .read_value_o(read_value), .action_done_o(action_done)
  );

  ntt_scoreboard u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .coef_index_i(coef_index), .coef_value_i(coef_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .read_value_i(read_value), .action_done_i(action_done),
    .errors_o(errors), .pending_o(pending)
  );

  task automatic send_item(input logic [1:0] act, input logic [7:0] idx,
                           input logic signed [15:0] val);
    in_valid   <= 1'b1;
    action     <= act;
    coef_index <= idx;
    coef_value <= val;
    do @(posedge clk); while (in_stall_s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'(int'($urandom_range(0, 6658)) - 3329);
      default: return 16'($urandom);
    endcase
  endfunction

  // output stall in random bursts, none once the run is winding down
  initial begin
    forever begin
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      if (!quiet && $urandom_range(0, 1) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  initial begin
    int r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, then fill the whole store before any transform
    send_item(ACT_WRITE, 8'd0, 16'sh8000);
    send_item(ACT_WRITE, 8'd255, 16'sh7fff);
    send_item(ACT_READ, 8'd0, 16'sh7fff);
    send_item(ACT_READ, 8'd255, 16'sh8000);
    for (int i = 1; i < 255; i++) send_item(ACT_WRITE, 8'(i), pick_value());
    send_item(ACT_FWD, 8'hff, 16'shffff);
    send_item(ACT_READ, 8'd0, '0);
    send_item(ACT_READ, 8'd255, '0);
    send_item(ACT_INV, 8'h00, 16'sh8000);
    send_item(ACT_READ, 8'd128, '0);
    send_item(ACT_FWD, '0, '0);
    send_item(ACT_INV, '0, '0);
    send_item(ACT_READ, 8'd7, '0);

    for (int n = 0; n < 314; n++) begin
      if (n == 250) quiet = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 45)      send_item(ACT_WRITE, 8'($urandom), pick_value());
      else if (r < 88) send_item(ACT_READ, 8'($urandom), 16'($urandom));
      else if (r < 94) send_item(ACT_FWD, 8'($urandom), 16'($urandom));
      else             send_item(ACT_INV, 8'($urandom), 16'($urandom));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
hdl/ntt_pkg.sv
hdl/ntt_ram.sv
hdl/ntt_bfly.sv
hdl/polynomial_ntt_engine_top.sv
hdl/ntt_checker.sv
verif/ntt_checker.sv
verif/tb_top.sv
